// ===== src/tdps_pkg.sv =====
// Package for the trial-division prime sieve.
// Holds table sizes, derived widths and the remainder unit status type.
// No dependencies.
package tdps_pkg;

  localparam int MaxPrimes = 64;
  localparam int ValueBits = 16;

  localparam int IdxBits   = $clog2(MaxPrimes);
  localparam int CountBits = $clog2(MaxPrimes + 1);
  localparam int StepBits  = $clog2(ValueBits + 1);

  typedef logic [ValueBits-1:0] value_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } rem_status_t;

endpackage

// ===== src/tdps_rem.sv =====
// Bit-serial remainder unit for the trial-division prime sieve.
// Restoring division, one dividend bit per cycle; reports a zero remainder.
// Depends on tdps_pkg.
module tdps_rem (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tdps_pkg::value_t     dividend,
  input  tdps_pkg::value_t     divisor,
  output tdps_pkg::rem_status_t status
);
  import tdps_pkg::*;

  logic                busy;
  logic                done;
  logic [StepBits-1:0] step;
  value_t              rem;
  value_t              quo;
  value_t              dvs;
  logic [ValueBits:0]  trial;
  logic [ValueBits:0]  diff;
  value_t              rem_next;

  always_comb begin
    trial = {rem, quo[ValueBits-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[ValueBits]) begin
      rem_next = diff[ValueBits-1:0];
    end else begin
      rem_next = trial[ValueBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + StepBits'(1);
        if (step == StepBits'(ValueBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[ValueBits-2:0], 1'b0};
    end
  end

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

// ===== src/trial_division_prime_sieve.sv =====
// Top level of the trial-division prime sieve.
// Holds the prime table memory, the sequencer and the output register.
// Depends on tdps_pkg and tdps_rem.
//
// Usage:
//   Input channel: number with in_valid / in_ready. Output channel:
//   prime_value and not_stored with out_valid / out_ready. An item is
//   moved when valid and ready are both high at a rising edge.
//   Each candidate is tested against the stored primes one at a time:
//   the table memory is read into a register, then the bit-serial
//   remainder unit works through the 16 dividend bits. A rejected
//   item stops at the first divisor found. The remainder unit sets the
//   rate. A passing item lands in the output register and is appended to
//   the table while room remains; a full table flags not_stored.
//   A new item is accepted as soon as the sequencer is idle, even while
//   the previous result waits in the output register; if the receiver
//   stalls, the next passing item holds until the register drains.
//   Reset (rst, synchronous) empties the table and the output register.
module trial_division_prime_sieve (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             prime_value,
  output logic                    not_stored
);
  import tdps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  value_t               prime_table [MaxPrimes];
  value_t               rd_data;
  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [IdxBits-1:0]   idx;
  logic [CountBits-1:0] count;
  value_t               cand;
  logic                 full;
  logic                 last;
  logic                 hit;
  logic                 load;
  logic                 wr_en;
  logic                 div_start;
  rem_status_t          status;

  assign in_ready  = (state == S_IDLE);
  assign full      = (count == CountBits'(MaxPrimes));
  assign last      = ((CountBits'(idx) + CountBits'(1)) == count);
  assign hit       = (rd_data == '0) ? (cand == '0) : status.rem_zero;
  assign load      = (state == S_EMIT) && (!out_valid || out_ready);
  assign wr_en     = load && !full;
  assign div_start = (state == S_START);

  tdps_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand),
    .divisor  (rd_data),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prime_table[count[IdxBits-1:0]] <= cand;
    end
    rd_data <= prime_table[idx];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (count == '0) ? S_EMIT : S_FETCH;
        end
      end
      S_FETCH: state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (status.done) begin
          priority if (hit) begin
            state_next = S_IDLE;
          end else if (last) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        idx <= '0;
      end else if ((state == S_DIV) && status.done && !hit && !last) begin
        idx <= idx + IdxBits'(1);
      end
      if (wr_en) begin
        count <= count + CountBits'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand <= number;
    end
    if (load) begin
      prime_value <= cand;
      not_stored  <= full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountBits'(MaxPrimes))
    else $error("prime count beyond table size");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (status.busy || status.done))
    else $error("waiting on an idle remainder unit");

  a_append: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + CountBits'(1)) && out_valid)
    else $error("table append without count step or result");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |-> (CountBits'(idx) < count))
    else $error("read of an unwritten table entry");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for trial_division_prime_sieve: a stream of candidates,
// mostly rising with random repeats, jumps and noise, checked against a sieve.
// Depends on tdps_pkg and the RTL top level.
module tb_top;
  import tdps_pkg::*;

  localparam int unsigned CycleLimit = 10_000_000;
  localparam int unsigned DrainCycles = 19 * MaxPrimes + 64;
  localparam int unsigned StreamItems = 1030;
  localparam int unsigned HoldResults = 30;
  localparam int unsigned HoldCycles = 3000;

  typedef struct {
    value_t value;
    logic   not_stored;
  } prime_result_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  value_t number = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  value_t prime_value;
  logic   not_stored;

  value_t        pending_numbers[$];
  prime_result_t expected_primes[$];
  value_t        sieve_primes[MaxPrimes];
  int unsigned   sieve_count = 0;
  int unsigned   send_gap = 0;
  int unsigned   recv_gap = 0;
  int unsigned   sent_count = 0;
  int unsigned   got_count = 0;
  int unsigned   hold_left = 0;
  int unsigned   hold_seen = 0;
  logic          hold_done = 1'b0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  value_t opening_numbers[18] = '{
    16'd0, 16'd0, 16'd2, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd65521, 16'd65534,
    16'd32768, 16'd65519, 16'd5, 16'd25, 16'd7, 16'd49, 16'd21845, 16'd11, 16'd65521
  };

  trial_division_prime_sieve u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .number      (number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_value (prime_value),
    .not_stored  (not_stored)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stretches of 40 items with no idling alternate with random gaps.
  function automatic int unsigned idle_draw(input int unsigned seq);
    if ((seq / 40) % 3 == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Test a candidate against the stored values; store a passing one while room remains.
  task automatic sieve_candidate(input value_t cand);
    logic          hit;
    logic          full;
    prime_result_t res;
    hit = 1'b0;
    for (int i = 0; i < sieve_count; i++) begin
      if (sieve_primes[i] == '0) begin
        if (cand == '0) hit = 1'b1;
      end else if (cand % sieve_primes[i] == '0) begin
        hit = 1'b1;
      end
    end
    if (!hit) begin
      full = (sieve_count >= MaxPrimes);
      if (!full) begin
        sieve_primes[sieve_count] = cand;
        sieve_count++;
      end
      res.value = cand;
      res.not_stored = full;
      expected_primes.push_back(res);
    end
  endtask

  always @(posedge clk) begin : sender
    logic        offer;
    int unsigned gap;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      sieve_count = 0;
    end else begin
      offer = in_valid;
      gap = send_gap;
      if (in_valid && in_ready) begin
        sieve_candidate(number);
        offer = 1'b0;
        sent_count++;
        gap = idle_draw(sent_count);
      end
      if (!offer) begin
        if (gap != 0) begin
          gap--;
        end else if (pending_numbers.size() != 0) begin
          number <= pending_numbers.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
      send_gap <= gap;
    end
  end

  always @(posedge clk) begin : receiver
    int unsigned   gap;
    prime_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = recv_gap;
      if (out_valid && out_ready) begin
        if (expected_primes.size() == 0) begin
          report_mismatch($sformatf("unexpected item %0d", prime_value));
        end else begin
          want = expected_primes.pop_front();
          if (prime_value !== want.value) begin
            report_mismatch($sformatf("prime_value %0d, want %0d", prime_value, want.value));
          end
          if (not_stored !== want.not_stored) begin
            report_mismatch($sformatf("not_stored %b for %0d, want %b",
                                      not_stored, want.value, want.not_stored));
          end
        end
        got_count++;
        gap = idle_draw(got_count);
      end else if (gap != 0) begin
        gap--;
      end
      recv_gap <= gap;
      out_ready <= (gap == 0) && (hold_left == 0);
    end
  end

  // Hold off the receiver once so the output register fills and input stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) hold_seen <= hold_seen + 1;
      if (!hold_done && hold_seen >= HoldResults) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    value_t      rising;
    value_t      last;
    foreach (opening_numbers[i]) pending_numbers.push_back(opening_numbers[i]);
    rising = 16'd12;
    last = rising;
    for (int k = 0; k < StreamItems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        pending_numbers.push_back(value_t'($urandom_range(2, 65535)));
      end else if (pick < 12) begin
        pending_numbers.push_back(last);
      end else begin
        if (pick < 18) rising = rising + value_t'($urandom_range(2, 40));
        pending_numbers.push_back(rising);
        last = rising;
        rising = rising + 1'b1;
      end
    end
    // Table is full by now: one still passes but is not kept.
    pending_numbers.push_back(16'd1);
    pending_numbers.push_back(16'd2);
    pending_numbers.push_back(16'd65519);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || in_valid) @(posedge clk);
    while (expected_primes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== trial_division_prime_sieve.f =====
src/tdps_pkg.sv
src/tdps_rem.sv
src/trial_division_prime_sieve.sv
bench/tb_top.sv
